// ----- hw/rtl/stun_binding_transaction_engine_assert.svh -----
// Assertion macros shared by the STUN binding transaction engine modules.
`ifndef STUN_BINDING_TRANSACTION_ENGINE_ASSERT_SVH
`define STUN_BINDING_TRANSACTION_ENGINE_ASSERT_SVH

// Clocked check, ignored while reset is asserted.
`define STUN_BTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define STUN_BTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/stun_bte_pkg.sv -----
// Types, constants and helpers of the STUN binding transaction engine.
`default_nettype none

package stun_bte_pkg;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_RESPONSE = 2'd1,
    OP_QUERY    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_REQ_BYTE = 2'd0,
    KIND_VERDICT  = 2'd1,
    KIND_PENDING  = 2'd2
  } kind_e;

  localparam int unsigned TIMEOUT_W = 40;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 40'd5000000000;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned EMIT_W = 5;
  localparam logic [EMIT_W-1:0] REQ_LAST_IDX = 5'd19;
  localparam logic [31:0] REQ_HEADER = 32'h0001_0000;

  // Byte positions inside the response datagram
  localparam logic [CNT_W-1:0] POS_ID_HI = 6'd4;
  localparam logic [CNT_W-1:0] POS_ID_LO = 6'd12;
  localparam logic [CNT_W-1:0] POS_ATTR  = 6'd20;
  localparam logic [CNT_W-1:0] POS_PORT  = 6'd26;
  localparam logic [CNT_W-1:0] POS_IPV4  = 6'd28;
  localparam logic [CNT_W-1:0] POS_LAST  = 6'd31;
  localparam logic [CNT_W-1:0] POS_END   = 6'd32;
  localparam logic [CNT_W-1:0] CNT_MAX   = 6'd63;

  // Fixed bytes of header and MAPPED-ADDRESS attribute
  function automatic logic [7:0] rsp_pattern_byte(input logic [CNT_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      6'd0:    b = 8'd1;
      6'd1:    b = 8'd1;
      6'd3:    b = 8'd12;
      6'd21:   b = 8'd1;
      6'd23:   b = 8'd8;
      6'd25:   b = 8'd1;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic [15:0] port;
    logic [31:0] ipv4;
    logic        check;
    logic        attr_good;
  } prs_t;

  typedef struct packed {
    logic                 en;
    logic                 store;
    logic                 erase;
    logic [63:0]          now;
    logic [TIMEOUT_W-1:0] timeout;
    logic [63:0]          look_hi;
    logic [63:0]          look_lo;
  } tbl_ctrl_t;

  typedef struct packed {
    logic hit;
    logic evicted;
    logic any;
  } tbl_stat_t;

  typedef struct packed {
    logic        load;
    kind_e       kind;
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic        ev;
    logic        ok;
    logic [15:0] port;
    logic [31:0] ipv4;
    logic        pend;
  } emit_load_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stun_bte_table.sv -----
// Pending transaction table: expiry, ID lookup, slot choice and update.
`default_nettype none
`include "stun_binding_transaction_engine_assert.svh"

module stun_bte_table #(
  parameter int unsigned N = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire stun_bte_pkg::tbl_ctrl_t ctrl_i,
  output      stun_bte_pkg::tbl_stat_t stat_o
);

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned NP = 2 ** $clog2(N);

  logic [N-1:0]  valid_q, valid_d;
  logic [63:0]   id_hi_q [N];
  logic [63:0]   id_lo_q [N];
  logic [63:0]   dl_q    [N];

  logic [N-1:0]  live, match;
  logic          hit, free_any;
  logic [IW-1:0] free_ix, slot;
  logic [63:0]   deadline;

  logic [63:0]   node_dl [2*NP-1];
  logic [IW-1:0] node_ix [2*NP-1];
  logic          node_ok [2*NP-1];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      live[i]  = valid_q[i] && !(dl_q[i] < ctrl_i.now);
      match[i] = live[i] && (id_hi_q[i] == ctrl_i.look_hi) && (id_lo_q[i] == ctrl_i.look_lo);
    end
  end

  assign hit      = |match;
  assign free_any = ~&live;

  always_comb begin
    free_ix = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_ix = IW'(i);
      end
    end
  end

  // Earliest deadline: tournament tree, left side wins a tie
  always_comb begin
    for (int k = 0; k < NP; k++) begin
      if (k < N) begin
        node_dl[NP-1+k] = dl_q[k];
        node_ix[NP-1+k] = IW'(k);
        node_ok[NP-1+k] = live[k];
      end else begin
        node_dl[NP-1+k] = '1;
        node_ix[NP-1+k] = '0;
        node_ok[NP-1+k] = 1'b0;
      end
    end
    for (int k = NP - 2; k >= 0; k--) begin
      if (!node_ok[2*k+1] || (node_ok[2*k+2] && (node_dl[2*k+2] < node_dl[2*k+1]))) begin
        node_dl[k] = node_dl[2*k+2];
        node_ix[k] = node_ix[2*k+2];
        node_ok[k] = node_ok[2*k+2];
      end else begin
        node_dl[k] = node_dl[2*k+1];
        node_ix[k] = node_ix[2*k+1];
        node_ok[k] = node_ok[2*k+1];
      end
    end
  end

  assign slot     = free_any ? free_ix : node_ix[0];
  assign deadline = ctrl_i.now + {{(64 - stun_bte_pkg::TIMEOUT_W){1'b0}}, ctrl_i.timeout};

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.en) begin
      valid_d = live;
      if (ctrl_i.store && !hit) begin
        valid_d[slot] = 1'b1;
      end
      if (ctrl_i.erase) begin
        valid_d = live & ~match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en && ctrl_i.store && !hit) begin
      id_hi_q[slot] <= ctrl_i.look_hi;
      id_lo_q[slot] <= ctrl_i.look_lo;
      dl_q[slot]    <= deadline;
    end
  end

  assign stat_o.hit     = hit;
  assign stat_o.evicted = !free_any;
  assign stat_o.any     = |live;

  // IDs are unique among live entries
  `STUN_BTE_ASSERT_ALWAYS(a_match_unique, $onehot0(match), "two live entries share an ID")
  `STUN_BTE_ASSERT(a_evict_full, (ctrl_i.store && !free_any) |-> (&live),
                   "eviction with a free slot")
  `STUN_BTE_ASSERT(a_store_live, (ctrl_i.en && ctrl_i.store && !ctrl_i.erase) |=> (|valid_q),
                   "table empty right after a request")

endmodule

`default_nettype wire

// ----- hw/rtl/stun_bte_parser.sv -----
// Response datagram parser: header and attribute checks, ID, port and address capture.
`default_nettype none

module stun_bte_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         data_i,
  input  wire logic               last_i,
  output      stun_bte_pkg::prs_t prs_o
);

  logic [stun_bte_pkg::CNT_W-1:0] cnt_q, cnt_d, pos;
  logic        hg_q, hg_d, ag_q, ag_d;
  logic [63:0] idh_q, idh_d, idl_q, idl_d;
  logic [15:0] port_q, port_d;
  logic [31:0] ip_q, ip_d;
  logic        chk;

  assign pos = cnt_q;
  assign chk = (data_i == stun_bte_pkg::rsp_pattern_byte(pos));

  always_comb begin
    hg_d   = hg_q;
    ag_d   = ag_q;
    idh_d  = idh_q;
    idl_d  = idl_q;
    port_d = port_q;
    ip_d   = ip_q;
    if (pos < stun_bte_pkg::POS_ID_HI) begin
      hg_d = hg_q & chk;
    end else if (pos inside {[stun_bte_pkg::POS_ATTR:stun_bte_pkg::POS_PORT - 6'd1]}) begin
      ag_d = ag_q & chk;
    end else if (pos < stun_bte_pkg::POS_ID_LO) begin
      idh_d = {idh_q[55:0], data_i};
    end else if (pos < stun_bte_pkg::POS_ATTR) begin
      idl_d = {idl_q[55:0], data_i};
    end else if (pos < stun_bte_pkg::POS_IPV4) begin
      port_d = {port_q[7:0], data_i};
    end else if (pos < stun_bte_pkg::POS_END) begin
      ip_d = {ip_q[23:0], data_i};
    end
    cnt_d = (cnt_q < stun_bte_pkg::CNT_MAX) ? cnt_q + 6'd1 : cnt_q;
  end

  // The last byte returns the parser to its idle values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hg_q   <= 1'b1;
      ag_q   <= 1'b1;
      idh_q  <= '0;
      idl_q  <= '0;
      port_q <= '0;
      ip_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        cnt_q  <= '0;
        hg_q   <= 1'b1;
        ag_q   <= 1'b1;
        idh_q  <= '0;
        idl_q  <= '0;
        port_q <= '0;
        ip_q   <= '0;
      end else begin
        cnt_q  <= cnt_d;
        hg_q   <= hg_d;
        ag_q   <= ag_d;
        idh_q  <= idh_d;
        idl_q  <= idl_d;
        port_q <= port_d;
        ip_q   <= ip_d;
      end
    end
  end

  assign prs_o.id_hi     = idh_q;
  assign prs_o.id_lo     = idl_q;
  assign prs_o.port      = port_d;
  assign prs_o.ipv4      = ip_d;
  assign prs_o.check     = (pos == stun_bte_pkg::POS_LAST) && hg_d;
  assign prs_o.attr_good = ag_d;

endmodule

`default_nettype wire

// ----- hw/rtl/stun_bte_emit.sv -----
// Result register and request byte sequencer.
`default_nettype none
`include "stun_binding_transaction_engine_assert.svh"

module stun_bte_emit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire stun_bte_pkg::emit_load_t load_i,
  input  wire logic                     ready_i,
  output      logic                     valid_o,
  output      logic                     last_o,
  output      logic [63:0]              data_o,
  output      logic [1:0]               user_o
);

  logic                            valid_q, valid_d;
  logic [stun_bte_pkg::EMIT_W-1:0] cnt_q, cnt_d;
  stun_bte_pkg::emit_load_t        pl_q;
  logic                            is_req, last, fire;
  logic [3:0]                      bidx, bsel;
  logic [1:0]                      hsel;
  logic [127:0]                    msg;
  logic [7:0]                      byte_v;

  assign is_req = (pl_q.kind == stun_bte_pkg::KIND_REQ_BYTE);
  assign last   = !is_req || (cnt_q == stun_bte_pkg::REQ_LAST_IDX);
  assign fire   = valid_q && ready_i;

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (fire) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 5'd1;
      end
    end
    if (load_i.load) begin
      valid_d = 1'b1;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      pl_q <= load_i;
    end
  end

  // Request bytes: 4 header bytes, then the ID most significant first
  assign msg  = {pl_q.id_hi, pl_q.id_lo};
  assign bidx = 4'(cnt_q - 5'd4);
  assign bsel = 4'd15 - bidx;
  assign hsel = 2'd3 - cnt_q[1:0];

  always_comb begin
    if (!is_req) begin
      byte_v = 8'd0;
    end else if (cnt_q < 5'd4) begin
      byte_v = stun_bte_pkg::REQ_HEADER[{hsel, 3'b000} +: 8];
    end else begin
      byte_v = msg[{bsel, 3'b000} +: 8];
    end
  end

  assign valid_o = valid_q;
  assign last_o  = last;
  assign user_o  = pl_q.kind;
  assign data_o  = {5'd0, pl_q.ev, pl_q.pend, pl_q.ipv4, pl_q.port, pl_q.ok, byte_v};

  `STUN_BTE_ASSERT(a_req_run, (fire && is_req && !last) |=> (valid_q && is_req),
                   "request run broken before its last byte")
  `STUN_BTE_ASSERT(a_cnt_range, valid_q |-> (cnt_q <= stun_bte_pkg::REQ_LAST_IDX),
                   "request byte counter out of range")
  `STUN_BTE_ASSERT(a_no_overrun, (valid_q && !(ready_i && last)) |-> !load_i.load,
                   "new item loaded over unfinished results")

endmodule

`default_nettype wire

// ----- hw/rtl/stun_binding_transaction_engine.sv -----
// An item is registered on acceptance and processed once the result register is free
// or about to be; processing loads its results into the result register.
// Throughput: one item per cycle while the result register is free or about to be;
// a request holds it for its 20 byte items, a query or verdict for its single result.
// Reset: table empty, response parser idle, timeout_ns back to 5000000000.
`default_nettype none

module stun_binding_transaction_engine #(
  parameter int unsigned MAX_PENDING = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [39:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // tdata: data_byte[7:0], now_ns[71:8], id_hi[135:72], id_lo[199:136]
  input  wire logic [199:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: out_byte[7:0], mapped_ok[8], mapped_port[24:9], mapped_ipv4[56:25],
  //        any_pending[57], evicted[58], zero[63:59]
  output      logic [63:0]  m_axis_tdata,
  // tuser: kind[1:0]
  output      logic [1:0]   m_axis_tuser,
  output      logic         m_axis_tlast
);

  logic [stun_bte_pkg::TIMEOUT_W-1:0] timeout_q;
  logic        in_valid_q, in_last_q;
  logic [1:0]  in_op_q;
  logic [7:0]  in_data_q;
  logic [63:0] in_now_q, in_idh_q, in_idl_q;
  logic        accept, consume, is_req, is_rsp, is_qry;

  stun_bte_pkg::prs_t       prs;
  stun_bte_pkg::tbl_ctrl_t  tctrl;
  stun_bte_pkg::tbl_stat_t  tstat;
  stun_bte_pkg::emit_load_t eload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= stun_bte_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // An item is processed once the result register is free or about to be
  assign consume       = in_valid_q && (!m_axis_tvalid || (m_axis_tready && m_axis_tlast));
  assign s_axis_tready = !in_valid_q || consume;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
      in_data_q <= s_axis_tdata[7:0];
      in_now_q  <= s_axis_tdata[71:8];
      in_idh_q  <= s_axis_tdata[135:72];
      in_idl_q  <= s_axis_tdata[199:136];
    end
  end

  assign is_req = (in_op_q == stun_bte_pkg::OP_REQUEST);
  assign is_rsp = (in_op_q == stun_bte_pkg::OP_RESPONSE);
  assign is_qry = (in_op_q == stun_bte_pkg::OP_QUERY);

  stun_bte_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (consume && is_rsp),
    .data_i (in_data_q),
    .last_i (in_last_q),
    .prs_o  (prs)
  );

  always_comb begin
    tctrl.en      = consume;
    tctrl.store   = consume && is_req;
    tctrl.erase   = consume && is_rsp && in_last_q && prs.check;
    tctrl.now     = in_now_q;
    tctrl.timeout = timeout_q;
    tctrl.look_hi = is_req ? in_idh_q : prs.id_hi;
    tctrl.look_lo = is_req ? in_idl_q : prs.id_lo;
  end

  stun_bte_table #(
    .N (MAX_PENDING)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tctrl),
    .stat_o (tstat)
  );

  always_comb begin
    eload.load  = consume && (is_req || is_qry || (is_rsp && in_last_q));
    eload.kind  = is_req ? stun_bte_pkg::KIND_REQ_BYTE :
                  is_rsp ? stun_bte_pkg::KIND_VERDICT : stun_bte_pkg::KIND_PENDING;
    eload.id_hi = in_idh_q;
    eload.id_lo = in_idl_q;
    // a duplicate ID places nothing, so nothing is evicted
    eload.ev    = is_req && !tstat.hit && tstat.evicted;
    eload.ok    = is_rsp && prs.check && tstat.hit && prs.attr_good;
    eload.port  = eload.ok ? prs.port : 16'd0;
    eload.ipv4  = eload.ok ? prs.ipv4 : 32'd0;
    eload.pend  = is_qry && tstat.any;
  end

  stun_bte_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (eload),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .last_o  (m_axis_tlast),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
